[sv/utcl_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utcl_pkg
// Shared types and constants for the UTF-8 text cursor layout block.
// ----------------------------------------------------------------------------
package utcl_pkg;

  localparam int MAX_PAGES       = 16;
  localparam int GLYPHS_PER_PAGE = 256;
  localparam int PAGE_DEPTH      = 256;
  localparam int WIDTH_DEPTH     = MAX_PAGES * GLYPHS_PER_PAGE;
  localparam int WADDR_W         = $clog2(WIDTH_DEPTH);

  localparam logic [15:0] SCREEN_W_RST = 16'd256;
  localparam logic [15:0] SCREEN_H_RST = 16'd192;
  localparam logic [7:0]  CHAR_H_RST   = 8'd16;
  localparam logic [7:0]  CHAR_W_RST   = 8'd16;

  localparam logic [15:0] CP_NEWLINE = 16'h000A;
  localparam logic [15:0] CP_TAB     = 16'h0009;

  typedef enum logic [1:0] {
    CFG_SCREEN_W = 2'd0,
    CFG_SCREEN_H = 2'd1,
    CFG_CHAR_H   = 2'd2,
    CFG_CHAR_W   = 2'd3
  } utcl_cfg_e;

  typedef enum logic [1:0] {
    REQ_TEXT   = 2'd0,
    REQ_PAGE   = 2'd1,
    REQ_WIDTH  = 2'd2,
    REQ_CURSOR = 2'd3
  } utcl_req_e;

  typedef enum logic [1:0] {
    ST_PLACED  = 2'd0,
    ST_CONTROL = 2'd1,
    ST_MISSING = 2'd2,
    ST_BELOW   = 2'd3
  } utcl_status_e;

endpackage

[sv/utcl_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utcl_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module utcl_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[sv/utf8_text_cursor_layout.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_text_cursor_layout
// UTF-8 decoder with per-screen text cursor, page index and glyph width lookup.
// ----------------------------------------------------------------------------
// Path: a completing text beat has its page index read at the accepting edge,
//   then its glyph width is read, then its layout goes into the output reg
//   before it shows on the master side.
// Throughput: one beat per cycle while the master side accepts; the two memory reads sit in separate stages.
// Reset: config regs to defaults, cursors and decoder cleared, page index
//   valid bits cleared (entries read as absent); no clearing pass needed.
module utf8_text_cursor_layout
  import utcl_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // text_byte[7:0], table_index[19:8], table_value[27:20], pos_x[43:28], pos_y[59:44]
  input  logic [63:0] s_axis_tdata,
  // req_type[1:0], screen[2]
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // code_point[15:0], draw_x[31:16], draw_y[47:32], glyph_width[55:48]
  output logic [55:0] m_axis_tdata,
  // out_screen[0], status[2:1]
  output logic [2:0]  m_axis_tuser
);

  typedef struct packed {
    utcl_req_e   kind;
    logic        emit;
    logic        scr;
    logic [15:0] code;
    logic [11:0] idx;
    logic [7:0]  val;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
  } stage_t;

  // configuration
  logic [15:0] screen_w_q, screen_h_q;
  logic [7:0]  char_h_q, char_w_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      screen_w_q <= SCREEN_W_RST;
      screen_h_q <= SCREEN_H_RST;
      char_h_q   <= CHAR_H_RST;
      char_w_q   <= CHAR_W_RST;
    end else if (cfg_valid_i) begin
      case (utcl_cfg_e'(cfg_index_i))
        CFG_SCREEN_W: screen_w_q <= cfg_data_i;
        CFG_SCREEN_H: screen_h_q <= cfg_data_i;
        CFG_CHAR_H:   char_h_q   <= cfg_data_i[7:0];
        CFG_CHAR_W:   char_w_q   <= cfg_data_i[7:0];
        default:      ;
      endcase
    end
  end

  // pipeline handshake
  logic   v1_q, v2_q, out_v_q;
  stage_t s1_q, s2_q;
  logic   pv1_q, miss2_q;
  logic   out_free, move1, move2, accept;

  assign out_free      = !out_v_q || m_axis_tready;
  assign move2         = v2_q && (!s2_q.emit || out_free);
  assign move1         = v1_q && (!v2_q || move2);
  assign s_axis_tready = !v1_q || move1;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // stage 0: decode
  utcl_req_e   in_req;
  logic        in_scr;
  logic [7:0]  in_byte;
  logic [11:0] in_idx;
  logic [7:0]  in_val;
  logic [1:0]  bl_q, bl_d;
  logic [15:0] acc_q, acc_d;
  logic        seq_q, seq_d;
  logic        emit0, scr0;
  logic [15:0] code0;
  logic [1:0]  bl_dec;

  assign in_req  = utcl_req_e'(s_axis_tuser[1:0]);
  assign in_scr  = s_axis_tuser[2];
  assign in_byte = s_axis_tdata[7:0];
  assign in_idx  = s_axis_tdata[19:8];
  assign in_val  = s_axis_tdata[27:20];
  assign bl_dec  = bl_q - 2'd1;

  always_comb begin
    bl_d  = bl_q;
    acc_d = acc_q;
    seq_d = seq_q;
    emit0 = 1'b0;
    scr0  = in_scr;
    code0 = {8'd0, in_byte};
    if (in_req == REQ_TEXT) begin
      if (bl_q != 2'd0) begin
        bl_d  = bl_dec;
        acc_d = (bl_dec == 2'd1) ? (acc_q | {4'd0, in_byte[5:0], 6'd0})
                                 : (acc_q | {10'd0, in_byte[5:0]});
        emit0 = (bl_dec == 2'd0);
        scr0  = seq_q;
        code0 = acc_d;
      end else if (!in_byte[7]) begin
        emit0 = 1'b1;
      end else if (in_byte[7:5] == 3'b110) begin
        acc_d = {5'd0, in_byte[4:0], 6'd0};
        bl_d  = 2'd1;
        seq_d = in_scr;
      end else if (in_byte[7:4] == 4'b1110) begin
        acc_d = {in_byte[3:0], 12'd0};
        bl_d  = 2'd2;
        seq_d = in_scr;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bl_q  <= 2'd0;
      acc_q <= 16'd0;
      seq_q <= 1'b0;
    end else if (accept) begin
      bl_q  <= bl_d;
      acc_q <= acc_d;
      seq_q <= seq_d;
    end
  end

  // page index store
  logic [PAGE_DEPTH-1:0] pvalid_q;
  logic                  p_we, p_re;
  logic [7:0]            p_rdata;

  assign p_we = accept && (in_req == REQ_PAGE) && (in_idx[11:8] == 4'd0);
  assign p_re = accept && emit0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pvalid_q <= '0;
    end else if (p_we) begin
      pvalid_q[in_idx[7:0]] <= 1'b1;
    end
  end

  utcl_ram #(
    .Width (8),
    .Depth (PAGE_DEPTH)
  ) u_page_ram (
    .clk_i   (clk_i),
    .we_i    (p_we),
    .waddr_i (in_idx[7:0]),
    .wdata_i (in_val),
    .re_i    (p_re),
    .raddr_i (code0[15:8]),
    .rdata_o (p_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (accept) begin
      v1_q <= 1'b1;
    end else if (move1) begin
      v1_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q.kind  <= in_req;
      s1_q.emit  <= emit0;
      s1_q.scr   <= scr0;
      s1_q.code  <= code0;
      s1_q.idx   <= in_idx;
      s1_q.val   <= in_val;
      s1_q.pos_x <= s_axis_tdata[43:28];
      s1_q.pos_y <= s_axis_tdata[59:44];
      pv1_q      <= pvalid_q[code0[15:8]];
    end
  end

  // stage 1: glyph width store
  logic               miss1, w_we, w_re;
  logic [15:0]        w_raddr_full;
  logic [7:0]         w_rdata;

  assign miss1        = !pv1_q || (p_rdata >= 8'(MAX_PAGES));
  assign w_raddr_full = {p_rdata, s1_q.code[7:0]};
  assign w_we = v1_q && (s1_q.kind == REQ_WIDTH) &&
                ({5'd0, s1_q.idx} < 17'(WIDTH_DEPTH));
  assign w_re = move1 && s1_q.emit;

  utcl_ram #(
    .Width (8),
    .Depth (WIDTH_DEPTH)
  ) u_width_ram (
    .clk_i   (clk_i),
    .we_i    (w_we),
    .waddr_i (WADDR_W'(s1_q.idx)),
    .wdata_i (s1_q.val),
    .re_i    (w_re),
    .raddr_i (WADDR_W'(w_raddr_full)),
    .rdata_o (w_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (move1) begin
      v2_q <= 1'b1;
    end else if (move2) begin
      v2_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (move1) begin
      s2_q    <= s1_q;
      miss2_q <= miss1;
    end
  end

  // stage 2: cursor layout
  logic [15:0]  cx_q [2];
  logic [15:0]  cy_q [2];
  logic [15:0]  cur_x, cur_y, lf_y, tab_x, x0, y0, x1;
  logic [15:0]  nx, ny, dx, dy;
  logic [7:0]   gw;
  logic         wrap0;
  utcl_status_e st;

  assign cur_x = cx_q[s2_q.scr];
  assign cur_y = cy_q[s2_q.scr];
  assign lf_y  = cur_y + {8'd0, char_h_q} + 16'd1;
  assign tab_x = cur_x + {7'd0, char_w_q, 1'b0};
  assign wrap0 = ({1'b0, cur_x} + {9'd0, w_rdata}) >= {1'b0, screen_w_q};
  assign x0    = wrap0 ? 16'd0 : cur_x;
  assign y0    = wrap0 ? lf_y : cur_y;
  assign x1    = x0 + {8'd0, w_rdata} + 16'd1;

  always_comb begin
    nx = cur_x;
    ny = cur_y;
    dx = 16'd0;
    dy = 16'd0;
    gw = 8'd0;
    st = ST_PLACED;
    if (s2_q.code == CP_NEWLINE) begin
      nx = 16'd0;
      ny = lf_y;
      st = ST_CONTROL;
    end else if (s2_q.code == CP_TAB) begin
      st = ST_CONTROL;
      if (tab_x >= screen_w_q) begin
        nx = 16'd0;
        ny = lf_y;
      end else begin
        nx = tab_x;
      end
    end else if (miss2_q) begin
      st = ST_MISSING;
    end else begin
      dx = x0;
      dy = y0;
      nx = x0;
      ny = y0;
      if (({1'b0, y0} + {9'd0, char_h_q}) >= {1'b0, screen_h_q}) begin
        st = ST_BELOW;
      end else begin
        gw = w_rdata;
        if (x1 >= screen_w_q) begin
          nx = 16'd0;
          ny = y0 + {8'd0, char_h_q} + 16'd1;
        end else begin
          nx = x1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q[0] <= 16'd0;
      cx_q[1] <= 16'd0;
      cy_q[0] <= 16'd0;
      cy_q[1] <= 16'd0;
    end else if (move2) begin
      if (s2_q.kind == REQ_CURSOR) begin
        cx_q[s2_q.scr] <= s2_q.pos_x;
        cy_q[s2_q.scr] <= s2_q.pos_y;
      end else if (s2_q.emit) begin
        cx_q[s2_q.scr] <= nx;
        cy_q[s2_q.scr] <= ny;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (move2 && s2_q.emit) begin
      out_v_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (move2 && s2_q.emit) begin
      m_axis_tdata <= {gw, dy, dx, s2_q.code};
      m_axis_tuser <= {st, s2_q.scr};
    end
  end

  assign m_axis_tvalid = out_v_q;

`ifndef SYNTHESIS
  a_bl_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bl_q != 2'd3)
    else $error("decoder count out of range");

  a_wram_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(w_we && w_re))
    else $error("width store written and read in one cycle");

  a_pram_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(p_we && p_re))
    else $error("page store written and read in one cycle");

  a_s2_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && !move2) |=> (v2_q && $stable(s2_q)))
    else $error("stalled layout stage lost its beat");
`endif

endmodule
